// ===== rtl/hcbd_pkg.sv =====
package hcbd_pkg;

  // Decoder phases
  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_DATA    = 3'd1;
  localparam logic [2:0] PH_CRLF    = 3'd2;
  localparam logic [2:0] PH_TRAILER = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;
  localparam logic [2:0] PH_BAD     = 3'd5;
  localparam logic [2:0] PH_BIG     = 3'd6;
  localparam logic [2:0] PH_OVF     = 3'd7;

  // Body status codes
  localparam logic [2:0] ST_BUSY = 3'd0;
  localparam logic [2:0] ST_DONE = 3'd1;
  localparam logic [2:0] ST_BAD  = 3'd2;
  localparam logic [2:0] ST_BIG  = 3'd3;
  localparam logic [2:0] ST_OVF  = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_BODY_MODE      = 2'd0;
  localparam logic [1:0] REG_CONTENT_LENGTH = 2'd1;
  localparam logic [1:0] REG_MAX_BODY_SIZE  = 2'd2;

  // Framing characters
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  localparam int unsigned TOTAL_W = 33;
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic        body_mode;
    logic [31:0] content_length;
    logic [31:0] max_body_size;
  } cfg_t;

  typedef struct packed {
    logic digit_seen;
    logic in_extension;
    logic cr_pending;
    logic line_nonempty;
  } line_flags_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // Decode one ASCII hex digit
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    case (c) inside
      [8'h30:8'h39]: h.value = 4'(c - 8'h30);
      [8'h61:8'h66]: h.value = 4'(c - 8'h57);
      [8'h41:8'h46]: h.value = 4'(c - 8'h37);
      default:       h.ok = 1'b0;
    endcase
    return h;
  endfunction

  // Map a phase to the reported status
  function automatic logic [2:0] status_of(input logic [2:0] ph);
    logic [2:0] st;
    case (ph)
      PH_DONE: st = ST_DONE;
      PH_BAD:  st = ST_BAD;
      PH_BIG:  st = ST_BIG;
      PH_OVF:  st = ST_OVF;
      default: st = ST_BUSY;
    endcase
    return st;
  endfunction

endpackage

// ===== rtl/hcbd_in_if.sv =====
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/hcbd_out_if.sv =====
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [2:0] body_status;

  modport source (output valid, output payload_valid, output payload_byte,
                  output body_status, input ready);
  modport sink (input valid, input payload_valid, input payload_byte,
                input body_status, output ready);
endinterface

// ===== rtl/http_chunked_body_decoder.sv =====
// A byte accepted into the input register passes through the decoder step and
// is then loaded into the result register, visible to the sink from there on.
// Throughput: one byte per clock while the sink takes results; the combinational
// update of the decoder state between the input and result registers sets this rate.
// Reset: asynchronous, clears the phase to the size line, the counters, the line
// flags, the valid flags of both pipeline registers and the configuration registers.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hcbd_in_if.sink     din_i,
  hcbd_out_if.source  dout_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t                  cfg_q;
  logic                  in_valid_q;
  logic [7:0]            in_byte_q;
  logic [2:0]            phase_q, phase_d;
  logic [SIZE_WIDTH-1:0] rem_q, rem_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  line_flags_t           flags_q, flags_d;
  logic                  pay_valid_d;
  logic                  out_valid_q;
  logic                  out_pv_q;
  logic [7:0]            out_byte_q;
  logic [2:0]            out_status_q;
  logic                  out_free;
  logic                  advance;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BODY_MODE:      cfg_q.body_mode      <= cfg_data_i[0];
        REG_CONTENT_LENGTH: cfg_q.content_length <= cfg_data_i;
        REG_MAX_BODY_SIZE:  cfg_q.max_body_size  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or taken
  assign out_free    = !out_valid_q || dout_o.ready;
  assign advance     = in_valid_q && out_free;
  assign din_i.ready = !in_valid_q || advance;

  // Hold the input request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (din_i.ready) begin
      in_valid_q <= din_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (din_i.ready && din_i.valid) in_byte_q <= din_i.data_byte;
  end

  hcbd_step #(
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_step (
    .cfg_i       (cfg_q),
    .phase_i     (phase_q),
    .rem_i       (rem_q),
    .total_i     (total_q),
    .flags_i     (flags_q),
    .byte_i      (in_byte_q),
    .phase_o     (phase_d),
    .rem_o       (rem_d),
    .total_o     (total_d),
    .flags_o     (flags_d),
    .pay_valid_o (pay_valid_d)
  );

  // Advance decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      rem_q   <= '0;
      total_q <= '0;
      flags_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      total_q <= total_d;
      flags_q <= flags_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pv_q     <= pay_valid_d;
      out_byte_q   <= pay_valid_d ? in_byte_q : 8'd0;
      out_status_q <= status_of(phase_d);
    end
  end

  assign dout_o.valid         = out_valid_q;
  assign dout_o.payload_valid = out_pv_q;
  assign dout_o.payload_byte  = out_byte_q;
  assign dout_o.body_status   = out_status_q;

endmodule

// ===== rtl/hcbd_step.sv =====
module hcbd_step
  import hcbd_pkg::*;
#(
  parameter int unsigned SIZE_WIDTH = 32
) (
  input  cfg_t                   cfg_i,
  input  logic [2:0]             phase_i,
  input  logic [SIZE_WIDTH-1:0]  rem_i,
  input  logic [TOTAL_W-1:0]     total_i,
  input  line_flags_t            flags_i,
  input  logic [7:0]             byte_i,
  output logic [2:0]             phase_o,
  output logic [SIZE_WIDTH-1:0]  rem_o,
  output logic [TOTAL_W-1:0]     total_o,
  output line_flags_t            flags_o,
  output logic                   pay_valid_o
);

  localparam int unsigned SUM_W = (SIZE_WIDTH > 33) ? SIZE_WIDTH + 1 : 34;

  hex_t                  hex;
  logic [SUM_W-1:0]      sum_w;
  logic [TOTAL_W-1:0]    total_sat;
  logic                  too_big;
  logic                  fix_big;
  logic                  fix_done_now;
  logic [TOTAL_W-1:0]    total_inc;
  logic                  fix_done_after;
  logic [SIZE_WIDTH-1:0] rem_dec;
  logic                  size_ovf;

  assign hex = hex_decode(byte_i);

  // Sum of chunk sizes, saturating at the cap
  assign sum_w     = SUM_W'(total_i) + SUM_W'(rem_i);
  assign total_sat = (sum_w > SUM_W'(TOTAL_CAP)) ? TOTAL_CAP : sum_w[TOTAL_W-1:0];
  assign too_big   = (cfg_i.max_body_size != 32'd0) &&
                     (total_sat > {1'b0, cfg_i.max_body_size});

  // Fixed length checks
  assign fix_big        = (cfg_i.max_body_size != 32'd0) &&
                          (cfg_i.content_length > cfg_i.max_body_size);
  assign fix_done_now   = total_i >= {1'b0, cfg_i.content_length};
  assign total_inc      = total_i + TOTAL_W'(1);
  assign fix_done_after = total_inc >= {1'b0, cfg_i.content_length};

  assign rem_dec  = rem_i - SIZE_WIDTH'(1);
  assign size_ovf = rem_i[SIZE_WIDTH-1 -: 4] != 4'd0;

  // Advance the decoder by one byte
  always_comb begin
    phase_o     = phase_i;
    rem_o       = rem_i;
    total_o     = total_i;
    flags_o     = flags_i;
    pay_valid_o = 1'b0;

    if (!phase_i[2]) begin
      if (cfg_i.body_mode) begin
        if (fix_big) begin
          phase_o = PH_BIG;
        end else if (fix_done_now) begin
          phase_o = PH_DONE;
        end else begin
          pay_valid_o = 1'b1;
          total_o     = total_inc;
          if (fix_done_after) phase_o = PH_DONE;
        end
      end else begin
        case (phase_i)
          PH_SIZE: begin
            if (flags_i.cr_pending && byte_i == CHAR_LF) begin
              // end of size line
              if (!flags_i.digit_seen) begin
                phase_o = PH_BAD;
              end else begin
                flags_o = '0;
                total_o = total_sat;
                if (rem_i == '0) phase_o = PH_TRAILER;
                else if (too_big) phase_o = PH_BIG;
                else phase_o = PH_DATA;
              end
            end else if (flags_i.cr_pending && !flags_i.in_extension) begin
              phase_o = PH_BAD;
            end else begin
              flags_o.cr_pending = 1'b0;
              if (byte_i == CHAR_CR) begin
                flags_o.cr_pending = 1'b1;
              end else if (flags_i.in_extension) begin
                flags_o.in_extension = 1'b1;
              end else if (byte_i == CHAR_SEMI) begin
                flags_o.in_extension = 1'b1;
              end else if (!hex.ok) begin
                phase_o = PH_BAD;
              end else if (size_ovf) begin
                phase_o = PH_OVF;
              end else begin
                rem_o              = {rem_i[SIZE_WIDTH-5:0], hex.value};
                flags_o.digit_seen = 1'b1;
              end
            end
          end
          PH_DATA: begin
            pay_valid_o = 1'b1;
            rem_o       = rem_dec;
            if (rem_dec == '0) begin
              phase_o            = PH_CRLF;
              flags_o.cr_pending = 1'b0;
            end
          end
          PH_CRLF: begin
            if (!flags_i.cr_pending) begin
              if (byte_i == CHAR_CR) flags_o.cr_pending = 1'b1;
              else phase_o = PH_BAD;
            end else if (byte_i == CHAR_LF) begin
              flags_o = '0;
              rem_o   = '0;
              phase_o = PH_SIZE;
            end else begin
              phase_o = PH_BAD;
            end
          end
          default: begin
            // trailer: drop lines until an empty one
            if (flags_i.cr_pending && byte_i == CHAR_LF) begin
              if (!flags_i.line_nonempty) phase_o = PH_DONE;
              flags_o.cr_pending    = 1'b0;
              flags_o.line_nonempty = 1'b0;
            end else begin
              if (flags_i.cr_pending) flags_o.line_nonempty = 1'b1;
              if (byte_i == CHAR_CR) begin
                flags_o.cr_pending = 1'b1;
              end else begin
                flags_o.cr_pending    = 1'b0;
                flags_o.line_nonempty = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/hcbd_checker.sv =====
module hcbd_checker
  import hcbd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       payload_valid_i,
  input logic [7:0] payload_byte_i,
  input logic [2:0] body_status_i
);

  logic       out_acc;
  logic       term_seen_q;
  logic [2:0] term_status_q;

  assign out_acc = out_valid_i && out_ready_i;

  // Track the first final status delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_seen_q   <= 1'b0;
      term_status_q <= ST_BUSY;
    end else if (out_acc && !term_seen_q && body_status_i != ST_BUSY) begin
      term_seen_q   <= 1'b1;
      term_status_q <= body_status_i;
    end
  end

  // A final status never changes once delivered
  a_status_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && term_seen_q |-> body_status_i == term_status_q)
    else $error("final body status changed");

  // Payload bytes only go out while busy or on the last byte
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && payload_valid_i |-> body_status_i == ST_BUSY ||
      body_status_i == ST_DONE)
    else $error("payload byte with error status");

  // Non-payload results carry a zero byte
  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !payload_valid_i |-> payload_byte_i == 8'd0)
    else $error("nonzero byte without payload");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_valid_i) &&
      $stable(payload_byte_i) && $stable(body_status_i))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (dout_o.valid),
  .out_ready_i     (dout_o.ready),
  .payload_valid_i (dout_o.payload_valid),
  .payload_byte_i  (dout_o.payload_byte),
  .body_status_i   (dout_o.body_status)
);
